@@ hw/rtl/rzs_pkg.sv @@
// ----------------------------------------------------------------------------
// rzs_pkg - shared constants for the rolling z-score normaliser
// Field widths, fixed-point scaling, limits and register indexes.
// ----------------------------------------------------------------------------
package rzs_pkg;

   // default sizing of the storage
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int MAX_COLUMNS_DEF = 32;
   localparam int MAX_ROWS_DEF    = 65536;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 40;
   localparam int SQ_W     = 56;
   localparam int Z_W      = 16;
   localparam int COLIDX_W = 5;
   localparam int WL_W     = 7;
   localparam int CC_W     = 6;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_WINDOW  = 1'b0;
   localparam logic [0:0] REG_COLUMNS = 1'b1;

   // z-score scaling: Q3.12 result, so the squared ratio carries 24 fraction bits
   localparam int FRAC_SHIFT = 24;
   localparam int Z_LIMIT    = 20480;
   // quotient bits needed to cover Z_LIMIT squared, and bits of its root
   localparam int QUO_W      = 29;
   localparam int ROOT_W     = 15;

endpackage

@@ hw/rtl/rzs_sermul.sv @@
// ----------------------------------------------------------------------------
// rzs_sermul - bit-serial unsigned multiplier
// Shift-and-add over the multiplier one bit per cycle.
// ----------------------------------------------------------------------------
module rzs_sermul #(
   parameter int A_W = 8,
   parameter int B_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               busy,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W = A_W + B_W;
   localparam int C_W = $clog2(B_W + 1);

   logic [A_W-1:0] a_ff;
   logic [P_W-1:0] p_ff;
   logic [P_W-1:0] p_in;
   logic [A_W:0]   sum_in;
   logic [C_W-1:0] cnt_ff;
   logic           busy_ff;

   // add the multiplicand into the upper half when the low bit is set, then shift
   always_comb begin
      sum_in = {1'b0, p_ff[P_W-1:B_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      p_in   = {sum_in, p_ff[B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= C_W'(B_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - C_W'(1);
         if (cnt_ff == C_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         p_ff <= {A_W'(0), b};
      end else if (busy_ff) begin
         p_ff <= p_in;
      end
   end

   assign busy    = busy_ff;
   assign product = p_ff;

endmodule

@@ hw/rtl/rolling_zscore_normalizer.sv @@
// ----------------------------------------------------------------------------
// rolling_zscore_normalizer - per-column rolling z-score with clipping
// Keeps exact per-column sums over a rolling or expanding window and returns
// (n*x - S) / sqrt(n*Q - S*S) as Q3.12, clipped to +-5.0.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  req_    | in        | req_valid/req_stall | sample_value, is_missing, restart
//  rsp_    | out       | rsp_valid/rsp_stall | zscore, column_index,
//          |           |                     | zero_deviation, count_overflow
//  csr_    | in        | APB, pready high    | window_length @0, column_count @4
//
//  One transaction at a time: the setup states LOAD, SQR, UPDT and NUMC, the
//  three parallel serial multipliers in MUL (the longest set by the width of
//  n*x - S), one compare state, restoring division in DIV and a bitwise square
//  root in ROOT, then DONE hands off and the engine returns to IDLE; DIV and
//  ROOT are skipped when the window is flat, ROOT when the ratio clips at once.
//  Synchronous active-high reset clears control, counters and column valid bits;
//  the history ring is not cleared. A result waits in the output register while
//  the next transaction is taken; the engine holds only when that register is
//  still full at the end of the next one.
//
module rolling_zscore_normalizer #(
   parameter int MAX_WINDOW  = rzs_pkg::MAX_WINDOW_DEF,
   parameter int MAX_COLUMNS = rzs_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = rzs_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input transactions
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rzs_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                req_is_missing,
   input  logic                                req_restart,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rzs_pkg::Z_W-1:0]      rsp_zscore,
   output logic [rzs_pkg::COLIDX_W-1:0]        rsp_column_index,
   output logic                                rsp_zero_deviation,
   output logic                                rsp_count_overflow,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rzs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rzs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rzs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int SAMPLE_W = rzs_pkg::SAMPLE_W;
   localparam int SUM_W    = rzs_pkg::SUM_W;
   localparam int SQ_W     = rzs_pkg::SQ_W;
   localparam int Z_W      = rzs_pkg::Z_W;
   localparam int QUO_W    = rzs_pkg::QUO_W;
   localparam int ROOT_W   = rzs_pkg::ROOT_W;

   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int SPAN_W = $clog2(MAX_WINDOW + 1);
   localparam int RP_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int DEPTH  = MAX_WINDOW * MAX_COLUMNS;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NX_W   = ROW_W + 1 + SAMPLE_W;
   localparam int NUM_W  = ((NX_W > SUM_W) ? NX_W : SUM_W) + 1;
   localparam int DEV_W  = SQ_W + ROW_W;
   localparam int SS_W   = 2 * SUM_W;
   localparam int CMP_W  = (DEV_W > SS_W) ? DEV_W : SS_W;
   localparam int NSQ_W  = 2 * NUM_W;
   localparam int T_W    = NSQ_W + rzs_pkg::FRAC_SHIFT;
   localparam int DIV_W  = (T_W > DEV_W + QUO_W) ? T_W : DEV_W + QUO_W;
   localparam int K_W    = $clog2(QUO_W + 1);
   localparam int RSQ_W  = 2 * ROOT_W;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_LOAD = 10'b0000000010,
      ST_SQR  = 10'b0000000100,
      ST_UPDT = 10'b0000001000,
      ST_NUMC = 10'b0000010000,
      ST_MUL  = 10'b0000100000,
      ST_CMP  = 10'b0001000000,
      ST_DIV  = 10'b0010000000,
      ST_ROOT = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // ---------------------------------------------------------------- config
   logic [rzs_pkg::WL_W-1:0] window_length_ff;
   logic [rzs_pkg::CC_W-1:0] column_count_ff;
   logic                     csr_write;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
         column_count_ff  <= rzs_pkg::CC_W'(1);
      end else if (csr_write) begin
         case (csr_paddr[2])
            rzs_pkg::REG_WINDOW:  window_length_ff <= csr_pwdata[rzs_pkg::WL_W-1:0];
            rzs_pkg::REG_COLUMNS: column_count_ff  <= csr_pwdata[rzs_pkg::CC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rzs_pkg::REG_WINDOW:  csr_prdata = rzs_pkg::CSR_DATA_W'(window_length_ff);
         rzs_pkg::REG_COLUMNS: csr_prdata = rzs_pkg::CSR_DATA_W'(column_count_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------- handshakes
   logic req_accept;
   logic out_free;
   logic out_load;
   logic clear_stats;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid & ~req_stall;
   assign out_free    = ~rsp_valid | ~rsp_stall;
   assign out_load    = (state_ff == ST_DONE) & out_free;
   // a register write or a restart transaction drops all statistics
   assign clear_stats = csr_write | (req_accept & req_restart);

   // ------------------------------------------------------------- storage
   logic [SUM_W-1:0]    sum_mem [MAX_COLUMNS];
   logic [SQ_W-1:0]     sq_mem  [MAX_COLUMNS];
   logic [SAMPLE_W-1:0] ring_mem[DEPTH];

   logic [MAX_COLUMNS-1:0] col_valid_ff;
   logic [ROW_W-1:0]       rows_ff;
   logic [COL_W-1:0]       cur_col_ff;
   logic [RP_W-1:0]        ring_pos_ff;

   // --------------------------------------------------------- item / LOAD
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [CNT_W-1:0]           cols_w;
   logic [SPAN_W-1:0]          span_w;
   logic [COL_W-1:0]           c_w;
   logic [SLOT_W-1:0]          slot_w;
   logic                       rolling_w, evict_w, sat_w;
   logic [ROW_W-1:0]           n_w;

   logic [COL_W-1:0]        c_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [CNT_W-1:0]        cols_ff;
   logic [SPAN_W-1:0]       span_ff;
   logic                    rolling_ff, evict_ff, ovf_ff;
   logic [ROW_W-1:0]        n_ff;
   logic signed [31:0]      xsq_ff;
   logic [SUM_W-1:0]        sum_rd_ff;
   logic [SQ_W-1:0]         sq_rd_ff;
   logic [SAMPLE_W-1:0]     old_rd_ff;

   always_comb begin
      // clamp the column count and the window to their legal ranges
      if (column_count_ff == '0) begin
         cols_w = CNT_W'(1);
      end else if (32'(column_count_ff) > MAX_COLUMNS) begin
         cols_w = CNT_W'(MAX_COLUMNS);
      end else begin
         cols_w = CNT_W'(column_count_ff);
      end
      if (32'(window_length_ff) > MAX_WINDOW) begin
         span_w = SPAN_W'(MAX_WINDOW);
      end else begin
         span_w = SPAN_W'(window_length_ff);
      end
      c_w       = (32'(cur_col_ff) >= 32'(cols_w)) ? '0 : cur_col_ff;
      slot_w    = SLOT_W'(ring_pos_ff) * SLOT_W'(MAX_COLUMNS) + SLOT_W'(c_w);
      rolling_w = (span_w != '0);
      evict_w   = rolling_w & (32'(rows_ff) >= 32'(span_w));
      sat_w     = ~rolling_w & (32'(rows_ff) >= MAX_ROWS);
      if (rolling_w) begin
         n_w = (32'(rows_ff) + 1 < 32'(span_w)) ? ROW_W'(rows_ff + ROW_W'(1))
                                                 : ROW_W'(span_w);
      end else if (sat_w) begin
         n_w = ROW_W'(MAX_ROWS);
      end else begin
         n_w = rows_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= req_is_missing ? '0 : req_sample_value;
      end
      if (state_ff == ST_LOAD) begin
         c_ff       <= c_w;
         slot_ff    <= slot_w;
         cols_ff    <= cols_w;
         span_ff    <= span_w;
         rolling_ff <= rolling_w;
         evict_ff   <= evict_w;
         ovf_ff     <= sat_w;
         n_ff       <= n_w;
         xsq_ff     <= 32'(x_ff) * 32'(x_ff);
      end
   end

   // memory reads in LOAD, write-back in UPDT
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         sum_rd_ff <= sum_mem[c_w];
         sq_rd_ff  <= sq_mem[c_w];
         old_rd_ff <= ring_mem[slot_w];
      end
   end

   // ----------------------------------------------------------------- SQR
   logic signed [31:0]     oldsq_ff;
   logic signed [NX_W-1:0] nx_ff;
   logic                   valid_rd_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQR) begin
         oldsq_ff    <= 32'($signed(old_rd_ff)) * 32'($signed(old_rd_ff));
         nx_ff       <= NX_W'($signed({1'b0, n_ff})) * NX_W'(x_ff);
         valid_rd_ff <= col_valid_ff[c_ff];
      end
   end

   // ---------------------------------------------------------------- UPDT
   logic signed [SUM_W-1:0] s_old_w, s_w, s_ff;
   logic [SQ_W-1:0]         q_old_w, q_w, q_ff;

   always_comb begin
      s_old_w = valid_rd_ff ? $signed(sum_rd_ff) : '0;
      q_old_w = valid_rd_ff ? sq_rd_ff : '0;
      if (ovf_ff) begin
         // saturated expanding window: hold the sums
         s_w = s_old_w;
         q_w = q_old_w;
      end else begin
         s_w = s_old_w - (evict_ff ? SUM_W'($signed(old_rd_ff)) : '0) + SUM_W'(x_ff);
         q_w = q_old_w - (evict_ff ? SQ_W'(oldsq_ff) : '0) + SQ_W'(xsq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDT) begin
         s_ff          <= s_w;
         q_ff          <= q_w;
         sum_mem[c_ff] <= s_w;
         sq_mem[c_ff]  <= q_w;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_UPDT) && rolling_ff) begin
         ring_mem[slot_ff] <= x_ff;
      end
   end

   // the column counter advances once per transaction, rows and ring on its wrap
   always_ff @(posedge clock) begin
      if (reset || clear_stats) begin
         col_valid_ff <= '0;
         rows_ff      <= '0;
         cur_col_ff   <= '0;
         ring_pos_ff  <= '0;
      end else if (state_ff == ST_UPDT) begin
         col_valid_ff[c_ff] <= 1'b1;
         if (32'(c_ff) + 1 >= 32'(cols_ff)) begin
            cur_col_ff <= '0;
            if (32'(rows_ff) < MAX_ROWS) begin
               rows_ff <= rows_ff + ROW_W'(1);
            end
            if (rolling_ff) begin
               ring_pos_ff <= (32'(ring_pos_ff) + 1 >= 32'(span_ff)) ? '0
                                                                     : ring_pos_ff + RP_W'(1);
            end
         end else begin
            cur_col_ff <= c_ff + COL_W'(1);
         end
      end
   end

   // ---------------------------------------------------------- NUMC / MUL
   logic signed [NUM_W-1:0] num_w;
   logic [NUM_W-1:0]        num_mag_w;
   logic [SUM_W-1:0]        smag_w;
   logic                    num_neg_ff;
   logic                    mul_start;
   logic                    nq_busy, ss_busy, nsq_busy;
   logic [DEV_W-1:0]        nq_p;
   logic [SS_W-1:0]         ss_p;
   logic [NSQ_W-1:0]        nsq_p;

   always_comb begin
      num_w     = NUM_W'(nx_ff) - NUM_W'(s_ff);
      num_mag_w = num_w[NUM_W-1] ? NUM_W'(-num_w) : NUM_W'(num_w);
      smag_w    = s_ff[SUM_W-1] ? SUM_W'(-s_ff) : SUM_W'(s_ff);
   end

   assign mul_start = (state_ff == ST_NUMC);

   always_ff @(posedge clock) begin
      if (mul_start) begin
         num_neg_ff <= num_w[NUM_W-1];
      end
   end

   rzs_sermul #(.A_W(SQ_W), .B_W(ROW_W)) u_mul_nq (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (q_ff),
      .b       (n_ff),
      .busy    (nq_busy),
      .product (nq_p)
   );

   rzs_sermul #(.A_W(SUM_W), .B_W(SUM_W)) u_mul_ss (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (smag_w),
      .b       (smag_w),
      .busy    (ss_busy),
      .product (ss_p)
   );

   rzs_sermul #(.A_W(NUM_W), .B_W(NUM_W)) u_mul_nsq (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (num_mag_w),
      .b       (num_mag_w),
      .busy    (nsq_busy),
      .product (nsq_p)
   );

   // ------------------------------------------------------ CMP / DIV / ROOT
   logic [CMP_W-1:0]  dev_full_w;
   logic              flat_w;
   logic              flat_ff;
   logic              clip_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  d_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [K_W-1:0]    k_ff;
   logic              div_ge;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W-1:0] bit_ff;
   logic [ROOT_W-1:0] trial_w;
   logic [RSQ_W-1:0]  trial_sq_w;

   always_comb begin
      flat_w     = CMP_W'(nq_p) <= CMP_W'(ss_p);
      dev_full_w = CMP_W'(nq_p) - CMP_W'(ss_p);
      div_ge     = rem_ff >= d_ff;
      trial_w    = root_ff | bit_ff;
      trial_sq_w = RSQ_W'(trial_w) * RSQ_W'(trial_w);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_CMP: begin
            flat_ff <= flat_w;
            clip_ff <= 1'b0;
            rem_ff  <= DIV_W'(nsq_p) << rzs_pkg::FRAC_SHIFT;
            d_ff    <= DIV_W'(dev_full_w[DEV_W-1:0]) << QUO_W;
            quo_ff  <= '0;
            k_ff    <= K_W'(QUO_W);
         end
         ST_DIV: begin
            if ((k_ff == K_W'(QUO_W)) && div_ge) begin
               // ratio beyond the clip range: skip the rest
               clip_ff <= 1'b1;
            end else begin
               if (div_ge) begin
                  rem_ff <= rem_ff - d_ff;
               end
               quo_ff  <= {quo_ff[QUO_W-2:0], div_ge};
               d_ff    <= d_ff >> 1;
               k_ff    <= k_ff - K_W'(1);
               root_ff <= '0;
               bit_ff  <= ROOT_W'(1) << (ROOT_W - 1);
            end
         end
         ST_ROOT: begin
            if (trial_sq_w <= RSQ_W'(quo_ff)) begin
               root_ff <= trial_w;
            end
            bit_ff <= bit_ff >> 1;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- DONE
   logic [Z_W-1:0]        mag_w;
   logic signed [Z_W-1:0] z_w;

   always_comb begin
      if (clip_ff || (root_ff > ROOT_W'(rzs_pkg::Z_LIMIT))) begin
         mag_w = Z_W'(rzs_pkg::Z_LIMIT);
      end else begin
         mag_w = Z_W'(root_ff);
      end
      if (flat_ff) begin
         z_w = '0;
      end else if (num_neg_ff) begin
         z_w = $signed(-mag_w);
      end else begin
         z_w = $signed(mag_w);
      end
   end

   // hold a finished result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_load) begin
         rsp_valid <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_zscore         <= z_w;
         rsp_column_index   <= rzs_pkg::COLIDX_W'(c_ff);
         rsp_zero_deviation <= flat_ff;
         rsp_count_overflow <= ovf_ff;
      end
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_SQR;
         ST_SQR:  state_in = ST_UPDT;
         ST_UPDT: state_in = ST_NUMC;
         ST_NUMC: state_in = ST_MUL;
         ST_MUL:  if (~nq_busy & ~ss_busy & ~nsq_busy) state_in = ST_CMP;
         ST_CMP:  state_in = flat_w ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if ((k_ff == K_W'(QUO_W)) && div_ge) begin
               state_in = ST_DONE;
            end else if (k_ff == '0) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: if (bit_ff[0]) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ----------------------------------------------------------- assertions
   // result never leaves the clip range
   a_clip_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($signed(rsp_zscore) <= rzs_pkg::Z_LIMIT) &&
                     ($signed(rsp_zscore) >= -rzs_pkg::Z_LIMIT)))
      else $error("zscore outside clip range");

   // a flat window forces a zero score
   a_flat_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_deviation) |-> (rsp_zscore == '0))
      else $error("zero deviation with non-zero score");

   // the count-overflow flag is only raised in the expanding mode
   a_ovf_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count_overflow) |-> (window_length_ff == '0))
      else $error("count overflow in rolling mode");

   // an accepted transaction closes the input until its work is done
   a_accept_closes : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (req_stall && (state_ff == ST_LOAD)))
      else $error("input not closed after acceptance");

endmodule
